// ===== rtl/ias_pkg.sv =====
// Package for the IAS execute unit: widths, opcodes, status codes and
// controller/datapath command types. No dependencies.
package ias_pkg;

    localparam int WORD_BITS = 40;
    localparam int ADDR_BITS = 12;
    localparam int FIELD_BITS = 12;
    localparam int FIELD_HI_LSB = 20;

    localparam logic [7:0] OP_LOAD_MQ     = 8'h0A;
    localparam logic [7:0] OP_LOAD_MQ_M   = 8'h09;
    localparam logic [7:0] OP_STOR        = 8'h21;
    localparam logic [7:0] OP_LOAD        = 8'h01;
    localparam logic [7:0] OP_LOAD_NEG    = 8'h02;
    localparam logic [7:0] OP_LOAD_ABS    = 8'h03;
    localparam logic [7:0] OP_LOAD_NABS   = 8'h04;
    localparam logic [7:0] OP_ADD         = 8'h05;
    localparam logic [7:0] OP_SUB         = 8'h06;
    localparam logic [7:0] OP_ADD_ABS     = 8'h07;
    localparam logic [7:0] OP_SUB_ABS     = 8'h08;
    localparam logic [7:0] OP_MUL         = 8'h0B;
    localparam logic [7:0] OP_DIV         = 8'h0C;
    localparam logic [7:0] OP_JUMP_L      = 8'h0D;
    localparam logic [7:0] OP_JUMP_R      = 8'h0E;
    localparam logic [7:0] OP_JUMPP_L     = 8'h0F;
    localparam logic [7:0] OP_JUMPP_R     = 8'h10;
    localparam logic [7:0] OP_STOR_LEFT   = 8'h12;
    localparam logic [7:0] OP_STOR_RIGHT  = 8'h13;
    localparam logic [7:0] OP_LSH         = 8'h14;
    localparam logic [7:0] OP_RSH         = 8'h15;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;

    // controller -> datapath commands
    typedef struct packed {
        logic load;    // capture input item, run non-iterative ops
        logic start;   // start multiply or divide iteration
        logic step;    // one iteration step
        logic finish;  // fix signs, write back registers
    } ias_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic is_iter;  // latched op needs iteration
        logic last;     // final iteration step this cycle
    } ias_stat_t;

endpackage

// ===== rtl/ias_if.sv =====
// Valid/ready channel interface for the IAS execute unit.
// Payload type is a parameter; depends on nothing else.
interface ias_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ias_ctrl.sv =====
// Controller of the IAS execute unit: sequences capture, iteration and
// result hold. Depends on ias_pkg.
module ias_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output ias_pkg::ias_cmd_t cmd,
    input  ias_pkg::ias_stat_t stat
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DEC  = 4'b0010,
        S_RUN  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // accept when idle and the output slot is free or draining
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (stat.is_iter)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_RUN;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RUN:
            begin
                cmd.step = 1'b1;
                if (stat.last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ===== rtl/ias_datapath.sv =====
// Datapath of the IAS execute unit: AC/MQ, non-iterative ops, shift-add
// multiplier and restoring divider, one bit per cycle. Depends on ias_pkg.
module ias_datapath #(
    parameter int ADDR_BITS = ias_pkg::ADDR_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ias_pkg::ias_cmd_t              cmd,
    output ias_pkg::ias_stat_t             stat,
    input  logic [7:0]                     opcode,
    input  logic [11:0]                    address,
    input  logic signed [ias_pkg::WORD_BITS-1:0] mem_word,
    output logic signed [ias_pkg::WORD_BITS-1:0] acc_out,
    output logic signed [ias_pkg::WORD_BITS-1:0] mq_out,
    output logic                           store_enable,
    output logic signed [ias_pkg::WORD_BITS-1:0] store_word,
    output logic                           jump_taken,
    output logic                           jump_left,
    output logic [11:0]                    jump_target,
    output logic [1:0]                     status
);
    localparam int W  = ias_pkg::WORD_BITS;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0] ac_reg, ac_next, mq_reg, mq_next;
    logic         st_en_reg, st_en_next, j_tk_reg, j_tk_next, j_l_reg, j_l_next;
    logic [W-1:0] st_w_reg, st_w_next;
    logic [11:0]  j_t_reg, j_t_next;
    logic [1:0]   sts_reg, sts_next;
    logic         iter_reg, iter_next, mul_reg, mul_next;

    // iteration registers: magnitudes, partial result, counter, signs
    logic [W-1:0]  opa_reg, opb_reg, acc_reg;   // acc: mul high / div remainder
    logic [W-1:0]  lo_reg;                      // mul low / div quotient
    logic [CW-1:0] cnt_reg;
    logic          qneg_reg, rneg_reg;

    logic [W-1:0] m, addr_ext, abs_m, abs_ac, abs_mq;
    logic [W:0]   sum;
    logic [W-1:0] rtrial;
    logic [W:0]   rdiff;

    assign m        = mem_word;
    assign addr_ext = {{(W-ADDR_BITS){1'b0}}, address[ADDR_BITS-1:0]};
    assign abs_m    = m[W-1] ? (~m + 1'b1) : m;
    assign abs_ac   = ac_reg[W-1] ? (~ac_reg + 1'b1) : ac_reg;
    assign abs_mq   = mq_reg[W-1] ? (~mq_reg + 1'b1) : mq_reg;

    // iteration step logic
    assign sum    = {1'b0, acc_reg} + ((lo_reg[0]) ? {1'b0, opb_reg} : '0);
    assign rtrial = {acc_reg[W-2:0], opa_reg[W-1]};
    assign rdiff  = {1'b0, rtrial} - {1'b0, opb_reg};

    assign stat.is_iter = iter_reg;
    assign stat.last    = (cnt_reg == CW'(1));

    // instruction decode, result capture and final sign fix
    always_comb
    begin
        ac_next    = ac_reg;
        mq_next    = mq_reg;
        st_en_next = st_en_reg;
        st_w_next  = st_w_reg;
        j_tk_next  = j_tk_reg;
        j_l_next   = j_l_reg;
        j_t_next   = j_t_reg;
        sts_next   = sts_reg;
        iter_next  = iter_reg;
        mul_next   = mul_reg;
        if (cmd.load)
        begin
            st_en_next = 1'b0;
            st_w_next  = '0;
            j_tk_next  = 1'b0;
            j_l_next   = 1'b0;
            j_t_next   = '0;
            sts_next   = ias_pkg::ST_OK;
            iter_next  = 1'b0;
            mul_next   = 1'b0;
            case (opcode)
                ias_pkg::OP_LOAD_MQ:   ac_next = mq_reg;
                ias_pkg::OP_LOAD_MQ_M: mq_next = m;
                ias_pkg::OP_STOR:
                begin
                    st_en_next = 1'b1;
                    st_w_next  = ac_reg;
                end
                ias_pkg::OP_LOAD:      ac_next = m;
                ias_pkg::OP_LOAD_NEG:  ac_next = ~m + 1'b1;
                ias_pkg::OP_LOAD_ABS:  ac_next = abs_m;
                ias_pkg::OP_LOAD_NABS: ac_next = ~abs_m + 1'b1;
                ias_pkg::OP_ADD:       ac_next = ac_reg + m;
                ias_pkg::OP_ADD_ABS:   ac_next = ac_reg + abs_m;
                ias_pkg::OP_SUB:       ac_next = ac_reg - m;
                ias_pkg::OP_SUB_ABS:   ac_next = ac_reg - abs_m;
                ias_pkg::OP_MUL:
                begin
                    iter_next = 1'b1;
                    mul_next  = 1'b1;
                end
                ias_pkg::OP_DIV:
                begin
                    if (m == '0)
                        sts_next = ias_pkg::ST_DIVZERO;
                    else
                        iter_next = 1'b1;
                end
                ias_pkg::OP_JUMP_L, ias_pkg::OP_JUMP_R:
                begin
                    j_tk_next = 1'b1;
                    j_l_next  = (opcode == ias_pkg::OP_JUMP_L);
                    j_t_next  = 12'(addr_ext);
                end
                ias_pkg::OP_JUMPP_L, ias_pkg::OP_JUMPP_R:
                begin
                    if (!ac_reg[W-1])
                    begin
                        j_tk_next = 1'b1;
                        j_l_next  = (opcode == ias_pkg::OP_JUMPP_L);
                        j_t_next  = 12'(addr_ext);
                    end
                end
                ias_pkg::OP_STOR_LEFT:
                begin
                    st_en_next = 1'b1;
                    st_w_next  = m;
                    st_w_next[ias_pkg::FIELD_HI_LSB +: ias_pkg::FIELD_BITS] =
                        ac_reg[ias_pkg::FIELD_BITS-1:0];
                end
                ias_pkg::OP_STOR_RIGHT:
                begin
                    st_en_next = 1'b1;
                    st_w_next  = m;
                    st_w_next[ias_pkg::FIELD_BITS-1:0] = ac_reg[ias_pkg::FIELD_BITS-1:0];
                end
                ias_pkg::OP_LSH: ac_next = {ac_reg[W-2:0], 1'b0};
                ias_pkg::OP_RSH: ac_next = {ac_reg[W-1], ac_reg[W-1:1]};
                default:         sts_next = ias_pkg::ST_ILLEGAL;
            endcase
        end
        else if (cmd.finish)
        begin
            if (mul_reg)
            begin
                // sign-correct the 80-bit product
                if (qneg_reg)
                begin
                    mq_next = ~lo_reg + 1'b1;
                    ac_next = ~acc_reg + ((lo_reg == '0) ? W'(1) : W'(0));
                end
                else
                begin
                    mq_next = lo_reg;
                    ac_next = acc_reg;
                end
            end
            else
            begin
                mq_next = qneg_reg ? (~lo_reg + 1'b1) : lo_reg;
                ac_next = rneg_reg ? (~acc_reg + 1'b1) : acc_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac_reg    <= '0;
            mq_reg    <= '0;
            iter_reg  <= 1'b0;
            mul_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            ac_reg   <= ac_next;
            mq_reg   <= mq_next;
            iter_reg <= iter_next;
            mul_reg  <= mul_next;
            if (cmd.start)
                cnt_reg <= CW'(W);
            else if (cmd.step)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // result payload and iteration operands
    always_ff @(posedge clk)
    begin
        st_en_reg <= st_en_next;
        st_w_reg  <= st_w_next;
        j_tk_reg  <= j_tk_next;
        j_l_reg   <= j_l_next;
        j_t_reg   <= j_t_next;
        sts_reg   <= sts_next;
        if (cmd.load)
        begin
            opb_reg  <= abs_m;
            qneg_reg <= (opcode == ias_pkg::OP_MUL) ? (mq_reg[W-1] ^ m[W-1])
                                                   : (ac_reg[W-1] ^ m[W-1]);
            rneg_reg <= ac_reg[W-1];
            opa_reg  <= abs_ac;
            lo_reg   <= abs_mq;
        end
        if (cmd.start)
        begin
            acc_reg <= '0;
            if (!mul_reg)
                lo_reg <= '0;
        end
        else if (cmd.step)
        begin
            if (mul_reg)
            begin
                // shift-add: one multiplier bit per cycle
                acc_reg <= sum[W:1];
                lo_reg  <= {sum[0], lo_reg[W-1:1]};
            end
            else
            begin
                // restoring divide: one quotient bit per cycle
                opa_reg <= {opa_reg[W-2:0], 1'b0};
                if (!rdiff[W])
                begin
                    acc_reg <= rdiff[W-1:0];
                    lo_reg  <= {lo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    acc_reg <= rtrial;
                    lo_reg  <= {lo_reg[W-2:0], 1'b0};
                end
            end
        end
    end

    assign acc_out      = ac_reg;
    assign mq_out       = mq_reg;
    assign store_enable = st_en_reg;
    assign store_word   = st_w_reg;
    assign jump_taken   = j_tk_reg;
    assign jump_left    = j_l_reg;
    assign jump_target  = j_t_reg;
    assign status       = sts_reg;
endmodule

// ===== rtl/ias_instruction_execute_unit.sv =====
// IAS execute unit top level. Non-iterative instructions go from the transfer
// through decode to the result; MUL and DIV add one iteration step per word bit of
// the one-bit shift-add / restoring-divide unit and a sign fix;
// a divide by zero skips the iteration.
// One instruction at a time; next transfer once the result slot frees.
// Reset (rst_n low, asynchronous) clears AC, MQ and the controller.
module ias_instruction_execute_unit #(
    parameter int ADDR_BITS = ias_pkg::ADDR_BITS
) (
    input  logic clk,
    input  logic rst_n,
    ias_if.sink   in_ch,
    ias_if.source out_ch
);
    ias_pkg::ias_cmd_t  cmd;
    ias_pkg::ias_stat_t stat;

    ias_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ias_datapath #(.ADDR_BITS(ADDR_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (in_ch.data.opcode),
        .address      (in_ch.data.address),
        .mem_word     (in_ch.data.mem_word),
        .acc_out      (out_ch.data.acc_out),
        .mq_out       (out_ch.data.mq_out),
        .store_enable (out_ch.data.store_enable),
        .store_word   (out_ch.data.store_word),
        .jump_taken   (out_ch.data.jump_taken),
        .jump_left    (out_ch.data.jump_left),
        .jump_target  (out_ch.data.jump_target),
        .status       (out_ch.data.status)
    );

    // no new instruction while a multiply or divide iterates
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !in_ch.ready)
        else $error("transfer accepted during iteration");

    // a transfer leads to decode, never straight to a result
    a_accept_then_no_new_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && !out_ch.valid) |=> !out_ch.valid)
        else $error("result raised in accept cycle");

    // jump flags only with ok status
    a_jump_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.data.jump_taken) |-> (out_ch.data.status == ias_pkg::ST_OK))
        else $error("jump with error status");
endmodule

// ===== tb/ias_tb_pkg.sv =====
// Transfer payload types for the IAS execute unit testbench.
// Depends on ias_pkg for the word and address widths.
`timescale 1ns / 1ps
package ias_tb_pkg;

    import ias_pkg::*;

    // one instruction: opcode, address field X and the word M(X)
    typedef struct packed {
        logic [7:0]             opcode;
        logic [ADDR_BITS-1:0]   address;
        logic [WORD_BITS-1:0]   mem_word;
    } ias_in_t;

    // one executed instruction: registers, store request, jump decision
    typedef struct packed {
        logic [WORD_BITS-1:0]   acc_out;
        logic [WORD_BITS-1:0]   mq_out;
        logic                   store_enable;
        logic [WORD_BITS-1:0]   store_word;
        logic                   jump_taken;
        logic                   jump_left;
        logic [ADDR_BITS-1:0]   jump_target;
        logic [1:0]             status;
    } ias_out_t;

endpackage

// ===== tb/ias_instruction_execute_unit_chk.sv =====
// Checker for the IAS execute unit: watches both channels, keeps its own
// AC/MQ copy and compares each result. Depends on ias_pkg, ias_tb_pkg, ias_if.
`timescale 1ns / 1ps
module ias_instruction_execute_unit_chk (
    input  logic clk,
    input  logic rst_n,
    ias_if       in_ch,
    ias_if       out_ch,
    output int   errors,
    output int   pending
);

    import ias_pkg::*;
    import ias_tb_pkg::*;

    logic [WORD_BITS-1:0] acc;
    logic [WORD_BITS-1:0] mq;
    ias_out_t             expected_q[$];

    // execute one instruction on the local AC/MQ copy
    function automatic ias_out_t execute(ias_in_t ins);
        ias_out_t             r;
        logic [WORD_BITS-1:0] m;
        logic [WORD_BITS-1:0] abs_m;
        logic signed [79:0]   prod;
        longint               a;
        longint               b;
        m = ins.mem_word;
        abs_m = m[WORD_BITS-1] ? -m : m;
        r = '0;
        r.status = ST_OK;
        case (ins.opcode)
            OP_LOAD_MQ:    acc = mq;
            OP_LOAD_MQ_M:  mq = m;
            OP_STOR:
            begin
                r.store_enable = 1'b1;
                r.store_word = acc;
            end
            OP_LOAD:       acc = m;
            OP_LOAD_NEG:   acc = -m;
            OP_LOAD_ABS:   acc = abs_m;
            OP_LOAD_NABS:  acc = -abs_m;
            OP_ADD:        acc = acc + m;
            OP_ADD_ABS:    acc = acc + abs_m;
            OP_SUB:        acc = acc - m;
            OP_SUB_ABS:    acc = acc - abs_m;
            OP_MUL:
            begin
                prod = 80'($signed(mq)) * 80'($signed(m));
                acc = prod[79:40];
                mq = prod[39:0];
            end
            OP_DIV:
            begin
                if (m == '0)
                    r.status = ST_DIVZERO;
                else
                begin
                    a = longint'($signed(acc));
                    b = longint'($signed(m));
                    mq = WORD_BITS'(a / b);
                    acc = WORD_BITS'(a % b);
                end
            end
            OP_JUMP_L, OP_JUMP_R, OP_JUMPP_L, OP_JUMPP_R:
            begin
                // conditional forms jump only when AC is non-negative
                if (ins.opcode == OP_JUMP_L || ins.opcode == OP_JUMP_R || !acc[WORD_BITS-1])
                begin
                    r.jump_taken = 1'b1;
                    r.jump_left = (ins.opcode == OP_JUMP_L || ins.opcode == OP_JUMPP_L);
                    r.jump_target = ins.address;
                end
            end
            OP_STOR_LEFT:
            begin
                r.store_enable = 1'b1;
                r.store_word = m;
                r.store_word[FIELD_HI_LSB +: FIELD_BITS] = acc[FIELD_BITS-1:0];
            end
            OP_STOR_RIGHT:
            begin
                r.store_enable = 1'b1;
                r.store_word = m;
                r.store_word[FIELD_BITS-1:0] = acc[FIELD_BITS-1:0];
            end
            OP_LSH:        acc = acc << 1;
            OP_RSH:        acc = {acc[WORD_BITS-1], acc[WORD_BITS-1:1]};
            default:       r.status = ST_ILLEGAL;
        endcase
        r.acc_out = acc;
        r.mq_out = mq;
        return r;
    endfunction

    assign pending = expected_q.size();

    // predict on each input transfer, compare on each output transfer
    always @(posedge clk or negedge rst_n)
    begin
        ias_out_t e;
        ias_out_t got;
        if (!rst_n)
        begin
            acc = '0;
            mq = '0;
            errors = 0;
            expected_q.delete();
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                expected_q.push_back(execute(in_ch.data));
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.data;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result %p", $realtime, got);
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (got.acc_out !== e.acc_out || got.mq_out !== e.mq_out ||
                        got.store_enable !== e.store_enable ||
                        got.store_word !== e.store_word ||
                        got.jump_taken !== e.jump_taken ||
                        got.jump_left !== e.jump_left ||
                        got.jump_target !== e.jump_target || got.status !== e.status)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch\n  expected %p\n  actual   %p",
                                     $realtime, e, got);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/ias_instruction_execute_unit_tb.sv =====
// Top of the IAS execute unit testbench: clock, reset, instruction stimulus
// and verdict. Depends on ias_pkg, ias_tb_pkg, ias_if and the checker.
`timescale 1ns / 1ps
module ias_instruction_execute_unit_tb;

    import ias_pkg::*;
    import ias_tb_pkg::*;

    localparam int STALL_LIMIT = 3000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_request;
    int   hold_count;
    int   quiet_cycles;

    ias_if #(.payload_t(ias_in_t))  in_ch ();
    ias_if #(.payload_t(ias_out_t)) out_ch ();

    ias_instruction_execute_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    ias_instruction_execute_unit_chk i_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .errors  (errors),
        .pending (pending)
    );

    // generate clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // drive result ready: long hold when requested, else random stalls
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_count <= hold_request;
            hold_request <= 0;
            out_ch.ready <= 1'b0;
        end
        else if (hold_count > 0)
        begin
            hold_count <= hold_count - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // end the run when nothing transfers for too long
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [WORD_BITS-1:0] pick_word();
        logic [WORD_BITS-1:0] w;
        w = WORD_BITS'({$urandom, $urandom});
        case ($urandom_range(9))
            0: w = '0;
            1: w = WORD_BITS'(1);
            2: w = '1;
            3: w = {1'b1, {(WORD_BITS-1){1'b0}}};
            4: w = {1'b0, {(WORD_BITS-1){1'b1}}};
            5: w = WORD_BITS'($signed(16'($urandom)));
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] pick_opcode();
        logic [7:0] legal[21];
        logic [7:0] op;
        legal = '{OP_LOAD_MQ, OP_LOAD_MQ_M, OP_STOR, OP_LOAD, OP_LOAD_NEG, OP_LOAD_ABS,
                  OP_LOAD_NABS, OP_ADD, OP_SUB, OP_ADD_ABS, OP_SUB_ABS, OP_MUL, OP_DIV,
                  OP_JUMP_L, OP_JUMP_R, OP_JUMPP_L, OP_JUMPP_R, OP_STOR_LEFT,
                  OP_STOR_RIGHT, OP_LSH, OP_RSH};
        if ($urandom_range(99) < 90)
            op = legal[5'($urandom_range(20))];
        else
            op = 8'($urandom);
        return op;
    endfunction

    // offer one instruction, idling first at random, and wait for its transfer
    task automatic send(logic [7:0] op, logic [ADDR_BITS-1:0] addr, logic [WORD_BITS-1:0] m);
        ias_in_t ins;
        ins.opcode = op;
        ins.address = addr;
        ins.mem_word = m;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= ins;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic send_random(int count);
        repeat (count)
            send(pick_opcode(), ADDR_BITS'($urandom), pick_word());
    endtask

    initial
    begin
        logic [WORD_BITS-1:0] wmin;
        logic [WORD_BITS-1:0] wmax;
        wmin = {1'b1, {(WORD_BITS-1){1'b0}}};
        wmax = {1'b0, {(WORD_BITS-1){1'b1}}};
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 0;
        hold_count = 0;
        quiet_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every opcode, extreme words, wrap and divide corners
        send(OP_LOAD, 12'hFFF, wmin);
        send(OP_LOAD_NEG, 12'h000, wmin);
        send(OP_LOAD_ABS, 12'h555, wmin);
        send(OP_LOAD_NABS, 12'hAAA, wmax);
        send(OP_JUMPP_L, 12'h123, '0);
        send(OP_JUMPP_R, 12'h321, '0);
        send(OP_ADD, 12'h001, wmax);
        send(OP_ADD_ABS, 12'h002, wmin);
        send(OP_SUB, 12'h003, wmax);
        send(OP_SUB_ABS, 12'h004, '1);
        send(OP_STOR, 12'hFFF, '0);
        send(OP_STOR_LEFT, 12'hFFF, '1);
        send(OP_STOR_RIGHT, 12'h000, '0);
        send(OP_LOAD_MQ_M, 12'h010, wmin);
        send(OP_MUL, 12'h020, wmin);
        send(OP_LOAD, 12'h030, wmin);
        send(OP_DIV, 12'h040, '1);
        send(OP_DIV, 12'h050, '0);
        send(OP_LOAD_MQ, 12'h060, '0);
        send(OP_LSH, 12'h070, '0);
        send(OP_RSH, 12'h080, '0);
        send(OP_JUMP_L, 12'hFFF, '0);
        send(OP_JUMP_R, 12'hABC, '1);
        send(8'hFF, 12'h000, '1);
        send(8'h00, 12'hFFF, wmax);

        // random, phase by phase
        send_random(140);
        send_idle_pct = 55;
        send_random(140);
        send_idle_pct = 0;
        recv_stall_pct = 55;
        send_random(140);
        send_idle_pct = 38;
        recv_stall_pct = 38;
        send_random(100);

        // long receiver hold while instructions keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request <= 300;
        send_random(100);

        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ias_pkg.sv
rtl/ias_if.sv
rtl/ias_ctrl.sv
rtl/ias_datapath.sv
rtl/ias_instruction_execute_unit.sv
tb/ias_tb_pkg.sv
tb/ias_instruction_execute_unit_chk.sv
tb/ias_instruction_execute_unit_tb.sv
